FILE: rtl/pps_pkg.sv
// Shared types and codes for the preemptive priority scheduler.
package pps_pkg;

   localparam int PrioW = 16;
   localparam int BurstW = 16;
   localparam int TimeW = 32;
   localparam int RspSlotW = 4;

   // Result status codes
   localparam logic [1:0] ST_LOADED = 2'd0;
   localparam logic [1:0] ST_RAN    = 2'd1;
   localparam logic [1:0] ST_IDLE   = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   // Request kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Running best candidate handed from cell to cell during a scan
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [PrioW-1:0]  prio;
      logic [BurstW-1:0] burst;
      logic [BurstW-1:0] remain;
   } cand_type;

   // Entry write broadcast to all cells
   typedef struct packed {
      logic              en;
      logic [PrioW-1:0]  prio;
      logic [BurstW-1:0] burst;
   } load_type;

endpackage

FILE: rtl/pps_cell.sv
// One table slot of the scheduler: holds an entry and relays the scan candidate.
module pps_cell #(
   parameter int MAX_PROCS = 16,
   parameter int IDX = 0,
   localparam int SlotW = $clog2(MAX_PROCS)
) (
   input  logic               clock,
   input  logic               reset,
   input  pps_pkg::load_type  load,
   input  logic [SlotW-1:0]   load_slot,
   input  logic               grant_en,
   input  logic [SlotW-1:0]   grant_slot,
   input  pps_pkg::cand_type  cand_in,
   input  logic [SlotW-1:0]   cand_slot_in,
   output pps_pkg::cand_type  cand_out,
   output logic [SlotW-1:0]   cand_slot_out
);
   import pps_pkg::*;

   localparam logic [SlotW-1:0] MyIdx = SlotW'(IDX);

   logic              used_ff, used_in;
   logic              done_ff, done_in;
   logic [PrioW-1:0]  prio_ff, prio_in;
   logic [BurstW-1:0] burst_ff, burst_in;
   logic [BurstW-1:0] remain_ff, remain_in;
   cand_type          cand_ff, cand_in_next;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic              take_own;

   // Compare own entry against the incoming candidate; strict less keeps lower slot on ties
   assign take_own = used_ff && !done_ff && (!cand_in.found || prio_ff < cand_in.prio);

   always_comb begin
      cand_in_next = cand_in;
      slot_in = cand_slot_in;
      if (take_own) begin
         cand_in_next.found  = 1'b1;
         cand_in_next.prio   = prio_ff;
         cand_in_next.burst  = burst_ff;
         cand_in_next.remain = remain_ff;
         slot_in = MyIdx;
      end
   end

   // Load a new entry or charge one time unit to the granted entry
   always_comb begin
      used_in   = used_ff;
      done_in   = done_ff;
      prio_in   = prio_ff;
      burst_in  = burst_ff;
      remain_in = remain_ff;
      if (load.en && load_slot == MyIdx) begin
         used_in   = 1'b1;
         done_in   = 1'b0;
         prio_in   = load.prio;
         burst_in  = load.burst;
         remain_in = load.burst;
      end else if (grant_en && grant_slot == MyIdx) begin
         remain_in = remain_ff - BurstW'(1);
         if (remain_ff == BurstW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         done_ff <= 1'b0;
         cand_ff <= '0;
      end else begin
         used_ff <= used_in;
         done_ff <= done_in;
         cand_ff <= cand_in_next;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff   <= prio_in;
      burst_ff  <= burst_in;
      remain_ff <= remain_in;
      slot_ff   <= slot_in;
   end

   assign cand_out = cand_ff;
   assign cand_slot_out = slot_ff;

endmodule

FILE: rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: request handling, cell chain, result register.
//
// Usage: items arrive on the req_ channel (valid/ready). kind 0 loads an entry
// (priority, burst length) into the next free slot; kind 1 runs one time unit
// for the unfinished entry with the lowest priority number, lowest slot on ties.
// Every item yields exactly one result on the rsp_ channel (valid/ready).
// A load is answered in the cycle after acceptance. A tick sends a candidate down
// the row of MAX_PROCS cells, one cell per cycle, and its result is registered
// when the candidate leaves the last cell. One item is in flight at a time.
// The result register is separate from the input side: a new item is taken
// in the cycle the waiting result is taken. While rsp_ready stays low the
// result holds and req_ready stays low.
// Reset clears the entry count, the done and in-use flags and the time counter;
// table contents are written by loads and need no clearing pass.
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_prio_value,
   input  logic [15:0] req_burst_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic        rsp_finished,
   output logic [31:0] rsp_completion_time,
   output logic [31:0] rsp_waiting_time
);
   import pps_pkg::*;

   localparam int SlotW = $clog2(MAX_PROCS);
   localparam int CntW = $clog2(MAX_PROCS + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(MAX_PROCS);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [TimeW-1:0] time_ff, time_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [RspSlotW-1:0] slot_ff, slot_in;
   logic               fin_ff, fin_in;
   logic [TimeW-1:0]   ct_ff, ct_in;
   logic [TimeW-1:0]   wt_ff, wt_in;

   logic             accept;
   logic             load_ok;
   load_type         load;
   logic [SlotW-1:0] load_slot;
   logic             grant_en;
   logic [BurstW-1:0] remain_next;
   logic             grant_fin;
   logic [TimeW-1:0] time_plus;

   cand_type         cand [MAX_PROCS+1];
   logic [SlotW-1:0] cand_slot [MAX_PROCS+1];

   // Take an item only when idle and the result register is free or being freed
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   assign load_ok = (count_ff != FullCount) && (req_burst_len != '0);
   assign load.en = accept && req_kind == KIND_LOAD && load_ok;
   assign load.prio = req_prio_value;
   assign load.burst = req_burst_len;
   assign load_slot = SlotW'(count_ff);

   // Launch an empty candidate into the head of the chain on a tick
   always_comb begin
      cand[0] = '0;
      cand[0].valid = accept && req_kind == KIND_TICK;
   end
   assign cand_slot[0] = '0;

   assign grant_en = cand[MAX_PROCS].valid && cand[MAX_PROCS].found;

   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      pps_cell #(
         .MAX_PROCS(MAX_PROCS),
         .IDX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .load(load),
         .load_slot(load_slot),
         .grant_en(grant_en),
         .grant_slot(cand_slot[MAX_PROCS]),
         .cand_in(cand[i]),
         .cand_slot_in(cand_slot[i]),
         .cand_out(cand[i+1]),
         .cand_slot_out(cand_slot[i+1])
      );
   end

   assign remain_next = cand[MAX_PROCS].remain - BurstW'(1);
   assign grant_fin = (remain_next == '0);
   assign time_plus = time_ff + TimeW'(1);

   // Sequence the item and build the result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      fin_in       = fin_ff;
      ct_in        = ct_ff;
      wt_in        = wt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_TICK) begin
                  state_in = S_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  fin_in = 1'b0;
                  wt_in = '0;
                  if (load_ok) begin
                     status_in = ST_LOADED;
                     slot_in = RspSlotW'(count_ff);
                     ct_in = time_ff;
                     count_in = count_ff + CntW'(1);
                  end else begin
                     status_in = ST_REJECT;
                     slot_in = '0;
                     ct_in = '0;
                  end
               end
            end
         end
         S_SCAN: begin
            if (cand[MAX_PROCS].valid) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               if (cand[MAX_PROCS].found) begin
                  status_in = ST_RAN;
                  slot_in = RspSlotW'(cand_slot[MAX_PROCS]);
                  fin_in = grant_fin;
                  time_in = time_plus;
                  ct_in = time_plus;
                  wt_in = grant_fin ? time_plus - TimeW'(cand[MAX_PROCS].burst) : '0;
               end else begin
                  status_in = ST_IDLE;
                  slot_in = '0;
                  fin_in = 1'b0;
                  ct_in = time_ff;
                  wt_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fin_ff    <= fin_in;
      ct_ff     <= ct_in;
      wt_ff     <= wt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_finished        = fin_ff;
   assign rsp_completion_time = ct_ff;
   assign rsp_waiting_time    = wt_ff;

   // The candidate leaves the chain only while a tick is being scanned
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      cand[MAX_PROCS].valid |-> state_ff == S_SCAN)
      else $error("scan candidate left the chain outside a tick");

   // The table never holds more than MAX_PROCS entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("entry count beyond table size");

   // A finished flag only comes with a granted slot
   a_fin_ran: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fin_ff |-> status_ff == ST_RAN)
      else $error("finished flag on a result that ran nothing");

   // An accepted tick starts a scan and leaves no result pending
   a_tick_scan: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_TICK |=> state_ff == S_SCAN && !rsp_valid_ff)
      else $error("tick did not start a scan");

   // Time advances only on a tick that granted a slot
   a_time_step: assert property (@(posedge clock) disable iff (reset)
      !grant_en |=> $stable(time_ff))
      else $error("time moved without a grant");

endmodule
